### hw/rtl/lfl_pkg.sv
package lfl_pkg;

    localparam int unsigned ENTRY_W  = 5;
    localparam int unsigned STATUS_W = 2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_USED  = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [ENTRY_W-1:0] entry_number;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  granted_entry;
    } t_rsp;

endpackage

### hw/rtl/lfl_chan_if.sv
interface lfl_chan_if #(
    parameter type T_PAYLOAD = lfl_pkg::t_req
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/linked_free_list_allocator_unit.sv
// channel  | dir | payload                          | handshake
// i_req    | in  | operation, entry_number          | valid/ready
// o_rsp    | out | status, granted_entry            | valid/ready
//
// Allocate reads the free head's link before it answers, and answers at once
// when the pool is exhausted; release walks the in-use links (at most
// POOL_ENTRIES), one registered read of the link memory per link, then
// unlinks a found entry and frees it, or answers not-used.
// Reset clears the link valid bits at once; no clearing pass.
// A request is taken while idle and the result register is empty or draining.
module linked_free_list_allocator_unit #(
    parameter int unsigned POOL_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfl_chan_if.sink    i_req,
    lfl_chan_if.source  o_rsp
);

    localparam int unsigned IW = $clog2(POOL_ENTRIES);
    localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);
    localparam int unsigned CW = (LW > lfl_pkg::ENTRY_W) ? LW : lfl_pkg::ENTRY_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALLOC  = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_UNLINK = 3'd3;
    localparam logic [2:0] S_FREE   = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [LW-1:0]                r_free_head, n_free_head;
    logic [LW-1:0]                r_used_head, n_used_head;
    logic [LW-1:0]                r_prev, n_prev;
    logic [LW-1:0]                r_cur, n_cur;
    logic [LW-1:0]                r_steps, n_steps;
    logic                         r_from_head, n_from_head;
    logic [lfl_pkg::ENTRY_W-1:0]  r_num, n_num;
    logic                         r_out_valid, n_out_valid;
    lfl_pkg::t_rsp                r_rsp, n_rsp;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [LW-1:0] rd_link;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [LW-1:0] wr_link;
    logic          out_free;
    logic          req_take;
    logic [LW-1:0] cur;

    lfl_link_mem #(.DEPTH(POOL_ENTRIES)) u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_link (rd_link),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_link (wr_link)
    );

    assign out_free      = !r_out_valid || o_rsp.ready;
    assign i_req.ready   = (r_state == S_IDLE) && out_free;
    assign req_take      = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;
    assign cur           = r_from_head ? r_used_head : rd_link;

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_used_head = r_used_head;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_from_head = r_from_head;
        n_num       = r_num;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_rsp       = r_rsp;
        rd_en       = 1'b0;
        rd_addr     = r_free_head[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_cur[IW-1:0];
        wr_link     = r_free_head;

        unique case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    if (i_req.payload.operation == lfl_pkg::OP_ALLOC) begin
                        if (r_free_head == NULL_LINK) begin
                            n_out_valid         = 1'b1;
                            n_rsp.status        = lfl_pkg::ST_EXHAUSTED;
                            n_rsp.granted_entry = '0;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_ALLOC;
                        end
                    end else begin
                        n_num       = i_req.payload.entry_number;
                        n_prev      = NULL_LINK;
                        n_steps     = '0;
                        n_from_head = 1'b1;
                        n_state     = S_WALK;
                    end
                end
            end
            S_ALLOC: begin
                wr_en               = 1'b1;
                wr_addr             = r_free_head[IW-1:0];
                wr_link             = r_used_head;
                n_used_head         = r_free_head;
                n_free_head         = rd_link;
                n_out_valid         = 1'b1;
                n_rsp.status        = lfl_pkg::ST_OK;
                n_rsp.granted_entry = lfl_pkg::ENTRY_W'(r_free_head);
                n_state             = S_IDLE;
            end
            S_WALK: begin
                rd_addr = cur[IW-1:0];
                priority if (cur == NULL_LINK) begin
                    n_out_valid         = 1'b1;
                    n_rsp.status        = lfl_pkg::ST_NOT_USED;
                    n_rsp.granted_entry = '0;
                    n_state             = S_IDLE;
                end else if (CW'(cur) == CW'(r_num)) begin
                    rd_en   = 1'b1;
                    n_cur   = cur;
                    n_state = S_UNLINK;
                end else if (r_steps == NULL_LINK) begin
                    n_out_valid         = 1'b1;
                    n_rsp.status        = lfl_pkg::ST_NOT_USED;
                    n_rsp.granted_entry = '0;
                    n_state             = S_IDLE;
                end else begin
                    rd_en       = 1'b1;
                    n_prev      = cur;
                    n_steps     = r_steps + LW'(1);
                    n_from_head = 1'b0;
                end
            end
            S_UNLINK: begin
                if (r_prev == NULL_LINK) begin
                    n_used_head = rd_link;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_prev[IW-1:0];
                    wr_link = rd_link;
                end
                n_state = S_FREE;
            end
            S_FREE: begin
                wr_en               = 1'b1;
                wr_addr             = r_cur[IW-1:0];
                wr_link             = r_free_head;
                n_free_head         = r_cur;
                n_out_valid         = 1'b1;
                n_rsp.status        = lfl_pkg::ST_OK;
                n_rsp.granted_entry = '0;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_used_head <= NULL_LINK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_used_head <= n_used_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_steps     <= n_steps;
        r_from_head <= n_from_head;
        r_num       <= n_num;
        r_rsp       <= n_rsp;
    end

endmodule

### hw/rtl/lfl_link_mem.sv
module lfl_link_mem #(
    parameter int unsigned DEPTH = 32,
    localparam int unsigned IW = $clog2(DEPTH),
    localparam int unsigned LW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output logic [LW-1:0] o_rd_link,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [LW-1:0] i_wr_link
);

    logic [LW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [LW-1:0]    r_rd_raw;
    logic             r_rd_valid;
    logic [IW-1:0]    r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_raw   <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
            r_rd_addr  <= i_rd_addr;
        end
    end

    // unwritten entry links to its successor
    assign o_rd_link = r_rd_valid ? r_rd_raw : (LW'(r_rd_addr) + LW'(1));

endmodule
